// ===== hw/rtl/gpni_pkg.sv =====
// Shared types and constants of the passage neighbor index.
package gpni_pkg;

    localparam int MAX_PASSAGES = 32;
    localparam int COORD_BITS   = 24;
    localparam int IDX_BITS     = 5;
    localparam int BUCKET_BITS  = 16;
    localparam int NUM_SLOTS    = 6;
    localparam int SLOT_BITS    = 3;
    localparam int CNT_BITS     = $clog2(COORD_BITS + 1);

    localparam logic [BUCKET_BITS-1:0] BUCKET_RESET = BUCKET_BITS'(1000);

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [SLOT_BITS-1:0] LAST_LOAD_SLOT  = SLOT_BITS'(5);
    localparam logic [SLOT_BITS-1:0] LAST_QUERY_SLOT = SLOT_BITS'(2);

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } point_t;

    typedef struct packed {
        logic clr;
        logic load;
        logic cmp;
        logic shift;
    } cell_ctrl_t;

    typedef struct packed {
        point_t entry_cell;
        point_t exit_cell;
        point_t query_cell;
    } cell_bus_t;

    typedef struct packed {
        logic e;
        logic x;
    } match_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_STORE,
        ST_CMP,
        ST_WALK
    } state_t;

    // Cell coordinates within one cell of each other, at full precision.
    function automatic logic adjacent(input coord_t a, input coord_t b);
        logic [COORD_BITS:0] d;
        d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
        return (d == '0) || (d == (COORD_BITS+1)'(1)) || (d == '1);
    endfunction

    function automatic logic near_point(input point_t c, input point_t q);
        return adjacent(c.x, q.x) && adjacent(c.y, q.y) && adjacent(c.z, q.z);
    endfunction

endpackage

// ===== hw/rtl/gpni_div.sv =====
// Iterative floor divider: signed coordinate by unsigned bucket size.
module gpni_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  gpni_pkg::coord_t                 dividend,
    input  logic [gpni_pkg::BUCKET_BITS-1:0] divisor,
    output logic                             done,
    output gpni_pkg::coord_t                 quotient
);
    import gpni_pkg::*;

    logic [COORD_BITS-1:0]  q_reg;
    logic [BUCKET_BITS-1:0] r_reg;
    logic [BUCKET_BITS-1:0] d_reg;
    logic                   neg_reg;
    logic                   run_reg;
    logic                   done_reg;
    logic [CNT_BITS-1:0]    cnt_reg;
    logic [BUCKET_BITS:0]   trial;
    logic                   fit;
    logic [COORD_BITS-1:0]  mag;

    assign mag   = dividend[COORD_BITS-1] ? -dividend : dividend;
    assign trial = {r_reg, q_reg[COORD_BITS-1]};
    assign fit   = trial >= {1'b0, d_reg};

    // Shift one quotient bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_BITS'(COORD_BITS);
            end
            else if (run_reg)
            begin
                if (cnt_reg != '0)
                    cnt_reg <= cnt_reg - 1'b1;
                else
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= mag;
            r_reg   <= '0;
            d_reg   <= divisor;
            neg_reg <= dividend[COORD_BITS-1];
        end
        else if (run_reg && cnt_reg != '0)
        begin
            r_reg <= fit ? BUCKET_BITS'(trial - {1'b0, d_reg}) : trial[BUCKET_BITS-1:0];
            q_reg <= {q_reg[COORD_BITS-2:0], fit};
        end
    end

    // Round toward minus infinity for negative dividends
    always_comb
    begin
        if (!neg_reg)
            quotient = q_reg;
        else if (r_reg != '0)
            quotient = ~q_reg;
        else
            quotient = -q_reg;
    end

    assign done = done_reg;

endmodule

// ===== hw/rtl/gpni_cell.sv =====
// One passage slot: stored cells, neighbor test and match shift stage.
module gpni_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  gpni_pkg::cell_ctrl_t ctrl,
    input  gpni_pkg::cell_bus_t  bus,
    input  logic                sel,
    input  gpni_pkg::match_t     match_in,
    output gpni_pkg::match_t     match_out
);
    import gpni_pkg::*;

    logic   valid_reg;
    point_t entry_reg;
    point_t exit_reg;
    match_t match_reg;

    // Hold valid flag and match bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= '0;
        end
        else
        begin
            if (ctrl.clr)
                valid_reg <= 1'b0;
            else if (ctrl.load && sel)
                valid_reg <= 1'b1;
            if (ctrl.cmp)
            begin
                match_reg.e <= valid_reg && near_point(entry_reg, bus.query_cell);
                match_reg.x <= valid_reg && near_point(exit_reg, bus.query_cell);
            end
            else if (ctrl.shift)
                match_reg <= match_in;
        end
    end

    // Capture endpoint cells on load
    always_ff @(posedge clk)
    begin
        if (ctrl.load && sel)
        begin
            entry_reg <= bus.entry_cell;
            exit_reg  <= bus.exit_cell;
        end
    end

    assign match_out = match_reg;

endmodule

// ===== hw/rtl/grid_passage_neighbor_index_core.sv =====
// Top level of the passage neighbor index: sequencer, divider and cell chain.
//
// Usage: drive operation and its fields with start high while busy is low;
// that edge transfers the item. Clear and the unused code act at that edge
// and leave busy low. Load runs six floor divisions on one shared serial
// divider, then a store step. Query runs three divisions, the parallel
// neighbor tests in all 32 cells, then walks the match bits down the cell
// chain one cell per cycle, staying at a cell whose two endpoints match
// until both are given. Each result leaves in the cycle after it is found.
// Results appear on found, candidate_index, reversed and last_result for one
// cycle with strobe high; the receiver cannot stall, no result is held.
// An empty query gives one result with found low.
// bucket_size is to be written through cfg_we/cfg_wdata only while the block
// is idle; the block does not enforce this. A zero write becomes one. Reset
// clears all passages, sets bucket_size to 1000 and returns the block to idle.
module grid_passage_neighbor_index_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              cfg_we,
    input  logic [gpni_pkg::BUCKET_BITS-1:0]  cfg_wdata,
    input  logic [1:0]                        operation,
    input  logic [gpni_pkg::IDX_BITS-1:0]     passage_num,
    input  gpni_pkg::coord_t                  entry_x,
    input  gpni_pkg::coord_t                  entry_y,
    input  gpni_pkg::coord_t                  entry_z,
    input  gpni_pkg::coord_t                  exit_x,
    input  gpni_pkg::coord_t                  exit_y,
    input  gpni_pkg::coord_t                  exit_z,
    input  gpni_pkg::coord_t                  query_x,
    input  gpni_pkg::coord_t                  query_y,
    input  gpni_pkg::coord_t                  query_z,
    output logic                              strobe,
    output logic                              found,
    output logic [gpni_pkg::IDX_BITS-1:0]     candidate_index,
    output logic                              reversed,
    output logic                              last_result
);
    import gpni_pkg::*;

    state_t state_reg, state_next;

    logic [BUCKET_BITS-1:0] bucket_reg;
    logic [SLOT_BITS-1:0]   slot_reg;
    logic [SLOT_BITS-1:0]   slot_last_reg;
    logic                   is_load_reg;
    logic [IDX_BITS-1:0]    load_idx_reg;
    coord_t                 opnd_reg [NUM_SLOTS];
    coord_t                 res_reg  [NUM_SLOTS];
    logic [IDX_BITS-1:0]    head_reg;
    logic                   phase_reg;
    logic                   emitted_reg;

    logic                   strobe_reg;
    logic                   found_reg;
    logic [IDX_BITS-1:0]    cand_reg;
    logic                   rev_reg;
    logic                   last_reg;

    logic                   accept;
    logic                   div_start;
    logic                   div_done;
    coord_t                 div_q;
    cell_ctrl_t             ctrl;
    cell_bus_t              bus;
    match_t                 chain [MAX_PASSAGES+1];
    logic                   rest_any;

    // Walk decisions
    logic                   emit;
    logic                   emit_found;
    logic                   emit_rev;
    logic                   emit_last;
    logic                   walk_shift;
    logic                   walk_done;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    // Bucket size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bucket_reg <= BUCKET_RESET;
        else if (cfg_we)
            bucket_reg <= (cfg_wdata == '0) ? BUCKET_BITS'(1) : cfg_wdata;
    end

    // Divider
    assign div_start = (state_reg == ST_DIV_START);

    gpni_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (opnd_reg[slot_reg]),
        .divisor  (bucket_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Cell chain
    assign ctrl.clr   = accept && (operation == OP_CLEAR);
    assign ctrl.load  = (state_reg == ST_STORE);
    assign ctrl.cmp   = (state_reg == ST_CMP);
    assign ctrl.shift = walk_shift;

    assign bus.entry_cell = '{x: res_reg[0], y: res_reg[1], z: res_reg[2]};
    assign bus.exit_cell  = '{x: res_reg[3], y: res_reg[4], z: res_reg[5]};
    assign bus.query_cell = '{x: res_reg[0], y: res_reg[1], z: res_reg[2]};

    assign chain[MAX_PASSAGES] = '0;

    for (genvar i = 0; i < MAX_PASSAGES; i++)
    begin : g_cell
        gpni_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .bus       (bus),
            .sel       (load_idx_reg == IDX_BITS'(i)),
            .match_in  (chain[i+1]),
            .match_out (chain[i])
        );
    end

    // Any match left behind the head cell
    always_comb
    begin
        rest_any = 1'b0;
        for (int i = 1; i < MAX_PASSAGES; i++)
            rest_any = rest_any | chain[i].e | chain[i].x;
    end

    // Walk one head cell per step
    always_comb
    begin
        emit       = 1'b0;
        emit_found = 1'b1;
        emit_rev   = 1'b0;
        emit_last  = 1'b0;
        walk_shift = 1'b0;
        walk_done  = 1'b0;
        if (state_reg == ST_WALK)
        begin
            if (chain[0].e && !phase_reg)
            begin
                emit       = 1'b1;
                emit_last  = !chain[0].x && !rest_any;
                walk_shift = !chain[0].x;
            end
            else if (chain[0].x)
            begin
                emit       = 1'b1;
                emit_rev   = 1'b1;
                emit_last  = !rest_any;
                walk_shift = 1'b1;
            end
            else if (!rest_any)
            begin
                emit       = !emitted_reg;
                emit_found = 1'b0;
                emit_last  = 1'b1;
                walk_done  = 1'b1;
            end
            else
                walk_shift = 1'b1;
            if (emit && emit_last)
                walk_done = 1'b1;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept && (operation == OP_LOAD || operation == OP_QUERY))
                    state_next = ST_DIV_START;
            ST_DIV_START:
                state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
                if (div_done)
                begin
                    if (slot_reg != slot_last_reg)
                        state_next = ST_DIV_START;
                    else if (is_load_reg)
                        state_next = ST_STORE;
                    else
                        state_next = ST_CMP;
                end
            ST_STORE:
                state_next = ST_IDLE;
            ST_CMP:
                state_next = ST_WALK;
            ST_WALK:
                if (walk_done)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Sequencer counters and flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg    <= '0;
            head_reg    <= '0;
            phase_reg   <= 1'b0;
            emitted_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                slot_reg <= '0;
            else if (state_reg == ST_DIV_WAIT && div_done)
                slot_reg <= slot_reg + 1'b1;
            if (state_reg == ST_CMP)
            begin
                head_reg    <= '0;
                phase_reg   <= 1'b0;
                emitted_reg <= 1'b0;
            end
            else if (state_reg == ST_WALK)
            begin
                if (emit)
                    emitted_reg <= 1'b1;
                if (walk_shift)
                begin
                    head_reg  <= head_reg + 1'b1;
                    phase_reg <= 1'b0;
                end
                else if (emit)
                    phase_reg <= 1'b1;
            end
        end
    end

    // Capture operands and quotients
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            is_load_reg   <= (operation == OP_LOAD);
            slot_last_reg <= (operation == OP_LOAD) ? LAST_LOAD_SLOT : LAST_QUERY_SLOT;
            load_idx_reg  <= passage_num;
            if (operation == OP_LOAD)
            begin
                opnd_reg[0] <= entry_x;
                opnd_reg[1] <= entry_y;
                opnd_reg[2] <= entry_z;
            end
            else
            begin
                opnd_reg[0] <= query_x;
                opnd_reg[1] <= query_y;
                opnd_reg[2] <= query_z;
            end
            opnd_reg[3] <= exit_x;
            opnd_reg[4] <= exit_y;
            opnd_reg[5] <= exit_z;
        end
        if (state_reg == ST_DIV_WAIT && div_done)
            res_reg[slot_reg] <= div_q;
    end

    // Register the result transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strobe_reg <= 1'b0;
        else
            strobe_reg <= emit;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            found_reg <= emit_found;
            cand_reg  <= emit_found ? head_reg : '0;
            rev_reg   <= emit_rev;
            last_reg  <= emit_last;
        end
    end

    assign strobe          = strobe_reg;
    assign found           = found_reg;
    assign candidate_index = cand_reg;
    assign reversed        = rev_reg;
    assign last_result     = last_reg;

`ifndef ASSERT_OFF
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !found |-> last_result)
        else $error("empty query result not marked last");

    a_last_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last_result |=> !strobe)
        else $error("result after last result of a query");

    a_div_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV_WAIT)
        else $error("divider finished outside a division step");
`endif

endmodule

// ===== bench/grid_passage_neighbor_index_core_tb.sv =====
// Testbench of the passage neighbor index: random loads, clears and queries checked per result.
module grid_passage_neighbor_index_core_tb;
    import gpni_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;

    // Operation code with no function
    localparam logic [1:0] OP_SPARE = 2'd3;

    typedef struct {
        logic [1:0]          op;
        logic [IDX_BITS-1:0] idx;
        coord_t              ex, ey, ez, xx, xy, xz, qx, qy, qz;
        bit                  steady;
    } command_t;

    typedef struct {
        logic                found;
        logic [IDX_BITS-1:0] cand;
        logic                rev;
        logic                last;
    } match_rec_t;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic                   cfg_we;
    logic [BUCKET_BITS-1:0] cfg_wdata;
    logic [1:0]             operation;
    logic [IDX_BITS-1:0]    passage_num;
    coord_t                 entry_x, entry_y, entry_z, exit_x, exit_y, exit_z;
    coord_t                 query_x, query_y, query_z;
    logic                   strobe;
    logic                   found;
    logic [IDX_BITS-1:0]    candidate_index;
    logic                   reversed;
    logic                   last_result;

    // Predictor state: cell table and bucket size
    longint     pred_bucket;
    bit         pred_valid [MAX_PASSAGES];
    longint     pred_cell [MAX_PASSAGES][6];

    command_t   pending_cmds[$];
    match_rec_t expected_matches[$];
    command_t   accepted_cmd;
    int         error_count;
    int         idle_cycles;
    int         result_count;
    int         query_count;
    int         load_count;

    grid_passage_neighbor_index_core uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .operation(operation), .passage_num(passage_num),
        .entry_x(entry_x), .entry_y(entry_y), .entry_z(entry_z),
        .exit_x(exit_x), .exit_y(exit_y), .exit_z(exit_z),
        .query_x(query_x), .query_y(query_y), .query_z(query_z),
        .strobe(strobe), .found(found), .candidate_index(candidate_index),
        .reversed(reversed), .last_result(last_result)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Append one command to the pending queue
    task automatic enqueue_cmd(command_t c);
        pending_cmds = {pending_cmds, c};
    endtask

    // Floor division of a coordinate by the current bucket size
    function automatic longint floor_cell(coord_t c);
        longint a;
        longint q;
        a = longint'(c);
        q = a / pred_bucket;
        if ((a % pred_bucket) != 0 && a < 0)
            q -= 1;
        return q;
    endfunction

    function automatic bit within_one(longint a, longint b);
        return (a - b) >= -1 && (a - b) <= 1;
    endfunction

    // Update the table and queue the matches of one accepted command
    task automatic predict_matches(command_t c);
        longint     q [3];
        match_rec_t m;
        int         n;
        n = 0;
        case (c.op)
            OP_CLEAR:
                foreach (pred_valid[i]) pred_valid[i] = 1'b0;
            OP_LOAD:
            begin
                pred_cell[c.idx][0] = floor_cell(c.ex);
                pred_cell[c.idx][1] = floor_cell(c.ey);
                pred_cell[c.idx][2] = floor_cell(c.ez);
                pred_cell[c.idx][3] = floor_cell(c.xx);
                pred_cell[c.idx][4] = floor_cell(c.xy);
                pred_cell[c.idx][5] = floor_cell(c.xz);
                pred_valid[c.idx] = 1'b1;
            end
            OP_QUERY:
            begin
                q[0] = floor_cell(c.qx);
                q[1] = floor_cell(c.qy);
                q[2] = floor_cell(c.qz);
                for (int i = 0; i < MAX_PASSAGES; i++)
                begin
                    if (!pred_valid[i])
                        continue;
                    for (int e = 0; e < 2; e++)
                        if (within_one(pred_cell[i][3*e], q[0]) &&
                            within_one(pred_cell[i][3*e+1], q[1]) &&
                            within_one(pred_cell[i][3*e+2], q[2]))
                        begin
                            m = '{1'b1, IDX_BITS'(i), e[0], 1'b0};
                            expected_matches = {expected_matches, m};
                            n++;
                        end
                end
                if (n == 0)
                begin
                    m = '{1'b0, '0, 1'b0, 1'b0};
                    expected_matches = {expected_matches, m};
                end
                expected_matches[$].last = 1'b1;
            end
            default: ;
        endcase
    endtask

    // Driver: present the next command, hold it until transferred
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (start && !busy)
            start <= 1'b0;
        else if (!start && pending_cmds.size() > 0 &&
                 (pending_cmds[0].steady || $urandom_range(99) >= 13))
        begin
            operation   <= pending_cmds[0].op;
            passage_num <= pending_cmds[0].idx;
            entry_x <= pending_cmds[0].ex;
            entry_y <= pending_cmds[0].ey;
            entry_z <= pending_cmds[0].ez;
            exit_x  <= pending_cmds[0].xx;
            exit_y  <= pending_cmds[0].xy;
            exit_z  <= pending_cmds[0].xz;
            query_x <= pending_cmds[0].qx;
            query_y <= pending_cmds[0].qy;
            query_z <= pending_cmds[0].qz;
            start   <= 1'b1;
        end
    end

    // Monitor: predict on each command transfer, check each result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || strobe)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (start && !busy)
            begin
                accepted_cmd = pending_cmds.pop_front();
                predict_matches(accepted_cmd);
                if (accepted_cmd.op == OP_QUERY)
                    query_count++;
                if (accepted_cmd.op == OP_LOAD)
                    load_count++;
            end
            if (strobe)
            begin
                result_count++;
                if (expected_matches.size() == 0)
                begin
                    $error("unexpected result, candidate_index %0d", candidate_index);
                    error_count++;
                end
                else
                begin
                    match_rec_t m;
                    m = expected_matches.pop_front();
                    if (found !== m.found)
                    begin
                        $error("found: expected %0d, got %0d", m.found, found);
                        error_count++;
                    end
                    if (candidate_index !== m.cand)
                    begin
                        $error("candidate_index: expected %0d, got %0d",
                               m.cand, candidate_index);
                        error_count++;
                    end
                    if (reversed !== m.rev)
                    begin
                        $error("reversed: expected %0d, got %0d", m.rev, reversed);
                        error_count++;
                    end
                    if (last_result !== m.last)
                    begin
                        $error("last_result: expected %0d, got %0d",
                               m.last, last_result);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no transfer at all
    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("grid_passage_neighbor_index_core test failed");
            $finish;
        end
    end

    function automatic coord_t rand_coord();
        case ($urandom_range(3))
            0: return coord_t'($urandom);
            1: return coord_t'($signed($urandom_range(8000)) - 4000);
            2: return $urandom_range(1) ? coord_t'(24'h7FFFFF) : coord_t'(24'h800000);
            default: return coord_t'($signed($urandom_range(60000)) - 30000);
        endcase
    endfunction

    function automatic command_t make_cmd(logic [1:0] op, int idx);
        command_t c;
        c.op  = op;
        c.idx = IDX_BITS'(idx);
        c.ex = rand_coord(); c.ey = rand_coord(); c.ez = rand_coord();
        c.xx = rand_coord(); c.xy = rand_coord(); c.xz = rand_coord();
        c.qx = rand_coord(); c.qy = rand_coord(); c.qz = rand_coord();
        c.steady = 1'b0;
        return c;
    endfunction

    // Query near an endpoint so that matches are common
    function automatic command_t near_query(command_t src);
        command_t c;
        c = make_cmd(OP_QUERY, $urandom_range(31));
        c.qx = src.ex + coord_t'($signed($urandom_range(3000)) - 1500);
        c.qy = src.ey + coord_t'($signed($urandom_range(3000)) - 1500);
        c.qz = src.ez + coord_t'($signed($urandom_range(3000)) - 1500);
        return c;
    endfunction

    // Wait until every command and result has passed, then let the block settle
    task automatic drain();
        while (pending_cmds.size() > 0 || expected_matches.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_bucket(logic [BUCKET_BITS-1:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        pred_bucket = (v == 0) ? 1 : longint'(v);
    endtask

    // Random phase of loads, queries, clears and unused codes
    task automatic random_phase(int count);
        command_t c;
        command_t last_load;
        last_load = make_cmd(OP_LOAD, 0);
        for (int k = 0; k < count; k++)
        begin
            case ($urandom_range(19))
                0:       c = make_cmd(OP_CLEAR, $urandom_range(31));
                1:       c = make_cmd(OP_SPARE, $urandom_range(31));
                2, 3, 4, 5, 6, 7, 8:
                begin
                    c = make_cmd(OP_LOAD, $urandom_range(31));
                    if ($urandom_range(1))
                    begin
                        c.xx = c.ex + 24'sd500; c.xy = c.ey; c.xz = c.ez - 24'sd700;
                    end
                    last_load = c;
                end
                9, 10, 11, 12, 13, 14, 15: c = near_query(last_load);
                default: c = make_cmd(OP_QUERY, $urandom_range(31));
            endcase
            // Drive a stretch of commands with no random gaps before them
            c.steady = (k >= count / 2 && k < count / 2 + 20);
            enqueue_cmd(c);
        end
        drain();
    endtask

    initial
    begin
        command_t c;
        rst_n = 1'b0;
        start = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        operation = '0;
        passage_num = '0;
        {entry_x, entry_y, entry_z, exit_x, exit_y, exit_z} = '0;
        {query_x, query_y, query_z} = '0;
        error_count = 0;
        idle_cycles = 0;
        result_count = 0;
        query_count = 0;
        load_count = 0;
        pred_bucket = 1000;
        foreach (pred_valid[i]) pred_valid[i] = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty query, extremes, reload, clear, unused code
        enqueue_cmd(make_cmd(OP_QUERY, 0));
        c = make_cmd(OP_LOAD, 0);
        {c.ex, c.ey, c.ez} = {24'h7FFFFF, 24'h800000, 24'h000000};
        {c.xx, c.xy, c.xz} = {24'h800000, 24'h7FFFFF, 24'hFFFFFF};
        enqueue_cmd(c);
        c.op = OP_QUERY;
        {c.qx, c.qy, c.qz} = {24'h7FFFFF, 24'h800000, 24'h000000};
        enqueue_cmd(c);
        {c.qx, c.qy, c.qz} = {24'h800000, 24'h7FFFFF, 24'h000000};
        enqueue_cmd(c);
        c = make_cmd(OP_LOAD, 31);
        {c.ex, c.ey, c.ez, c.xx, c.xy, c.xz} = '0;
        enqueue_cmd(c);
        c.op = OP_QUERY;
        {c.qx, c.qy, c.qz} = {-24'sd1, 24'sd999, -24'sd1000};
        enqueue_cmd(c);
        c = make_cmd(OP_LOAD, 31);
        {c.ex, c.ey, c.ez, c.xx, c.xy, c.xz} = {6{24'sd5000}};
        enqueue_cmd(c);
        c.op = OP_QUERY;
        {c.qx, c.qy, c.qz} = {3{24'sd4000}};
        enqueue_cmd(c);
        c = make_cmd(OP_SPARE, 0);
        enqueue_cmd(c);
        c.op = OP_QUERY;
        {c.qx, c.qy, c.qz} = {3{24'sd4000}};
        enqueue_cmd(c);
        enqueue_cmd(make_cmd(OP_CLEAR, 0));
        enqueue_cmd(c);
        drain();

        // Settings: reset size, zero raised to one, the top, the minimum and a mid value
        random_phase(50);
        write_bucket(16'd0);
        random_phase(30);
        write_bucket(16'hFFFF);
        random_phase(40);
        write_bucket(16'd1);
        random_phase(30);
        write_bucket(16'd777);
        random_phase(50);

        $display("covered %0d loads and %0d queries, %0d results checked",
                 load_count, query_count, result_count);
        $display("bucket sizes 1000, 0, 65535, 1 and 777 were in force");
        if (error_count == 0 && expected_matches.size() == 0)
            $display("grid_passage_neighbor_index_core test passed");
        else
            $display("grid_passage_neighbor_index_core test failed");
        $finish;
    end
endmodule
